[src/ldbw_pkg.sv]
// Shared constants and types for the line draw bus write engine.
package ldbw_pkg;

   localparam int COORD_BITS = 16;
   localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

   localparam logic [15:0] CMD_COLWIN = 16'h002A;
   localparam logic [15:0] CMD_ROWWIN = 16'h002B;
   localparam logic [15:0] CMD_MEMWR  = 16'h002C;
   localparam logic [15:0] BYTE_MASK  = 16'h00FF;

   localparam int MODE_BITS = 3;
   localparam logic [MODE_BITS-1:0] MODE_IDLE    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_POINT   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_VERT    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_HORIZ   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_STEEP   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_SHALLOW = 3'd5;

   typedef struct packed {
      logic go;
      logic skip_window;
   } start_type;

   typedef struct packed {
      logic [15:0] col1;
      logic [15:0] col2;
      logic [15:0] row1;
      logic [15:0] row2;
      logic [15:0] color;
      logic        last_line;
   } win_type;

endpackage

[src/ldbw_if.sv]
// Valid/ready channel interfaces for draw requests and bus write beats.
interface ldbw_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] x_start;
   logic [15:0] y_start;
   logic [15:0] x_end;
   logic [15:0] y_end;
   logic [15:0] pixel_color;

   modport source (output valid, output func, output x_start, output y_start,
                   output x_end, output y_end, output pixel_color, input ready);
   modport sink   (input valid, input func, input x_start, input y_start,
                   input x_end, input y_end, input pixel_color, output ready);
endinterface

interface ldbw_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_command;
   logic [15:0] bus_value;
   logic        last_of_pixel;
   logic        last_of_line;

   modport source (output valid, output is_command, output bus_value,
                   output last_of_pixel, output last_of_line, input ready);
   modport sink   (input valid, input is_command, input bus_value,
                   input last_of_pixel, input last_of_line, output ready);
endinterface

[src/line_draw_bus_write_engine.sv]
// Top level of the line draw bus write engine.
//
//   channel   dir  beat
//   req_chan  in   func, x_start, y_start, x_end, y_end, pixel_color
//   rsp_chan  out  is_command, bus_value, last_of_pixel, last_of_line
//
// A load emits nothing. An advance latches the pixel window, then issues one
// bus write per cycle from the control store while rsp_chan is not stalled:
// 12 writes for points, sloped pixels and the first pixel of a run, 1 after.
// The control store program length sets the pace; the minor axis is stepped
// incrementally, one add and compare per pixel.
// Reset is synchronous and clears the line mode, the sequencer and rsp valid.
// A stalled rsp_chan holds the step counter; req_chan stays low until done.
module line_draw_bus_write_engine (
   input  logic        clock,
   input  logic        reset,
   ldbw_req_if.sink    req_chan,
   ldbw_rsp_if.source  rsp_chan
);
   import ldbw_pkg::*;

   start_type start;
   win_type   win;
   logic      busy;

   ldbw_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .busy     (busy),
      .start    (start),
      .win      (win)
   );

   ldbw_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .win      (win),
      .rsp_chan (rsp_chan),
      .busy     (busy)
   );

   a_line_end_is_pixel_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_of_line |-> rsp_chan.last_of_pixel)
      else $error("last_of_line without last_of_pixel");

   a_pixel_ends_in_color: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_of_pixel |-> !rsp_chan.is_command)
      else $error("pixel ended on a command write");

   a_command_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_command |->
         (rsp_chan.bus_value == CMD_COLWIN) || (rsp_chan.bus_value == CMD_ROWWIN) ||
         (rsp_chan.bus_value == CMD_MEMWR))
      else $error("unknown command code");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start.go |=> busy)
      else $error("sequencer did not start");

endmodule

[src/ldbw_datapath.sv]
// Line state, endpoint ordering and incremental minor-axis interpolation.
module ldbw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   ldbw_req_if.sink              req_chan,
   input  logic                  busy,
   output ldbw_pkg::start_type   start,
   output ldbw_pkg::win_type     win
);
   import ldbw_pkg::*;

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [15:0] maj_s_ff, maj_s_in;
   logic [15:0] maj_e_ff, maj_e_in;
   logic [15:0] min_s_ff, min_s_in;
   logic [15:0] span_ff, span_in;
   logic [15:0] absd_ff, absd_in;
   logic        neg_ff, neg_in;
   logic [16:0] step_ff, step_in;
   logic [15:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] color_ff, color_in;
   logic        sent_ff, sent_in;
   win_type     win_ff, win_in;

   logic        accept;
   logic [15:0] xs, ys, xe, ye, dx, dy;
   logic        swap;
   logic [15:0] maj, mnr, px, py;
   logic [16:0] rem_sum;
   logic        wrap;
   logic        last_line;

   assign req_chan.ready = !busy;
   assign accept = req_chan.valid && !busy;
   assign win = win_ff;

   always_comb begin
      xs = req_chan.x_start & COORD_MASK;
      ys = req_chan.y_start & COORD_MASK;
      xe = req_chan.x_end & COORD_MASK;
      ye = req_chan.y_end & COORD_MASK;
      dx = (xs > xe) ? xs - xe : xe - xs;
      dy = (ys > ye) ? ys - ye : ye - ys;
      swap = 1'b0;

      maj = maj_s_ff + step_ff[15:0];
      mnr = neg_ff ? min_s_ff - quot_ff : min_s_ff + quot_ff;
      if (mode_ff == MODE_STEEP) begin
         px = mnr;
         py = maj;
      end else begin
         px = maj;
         py = mnr;
      end
      rem_sum = {1'b0, rem_ff} + {1'b0, absd_ff};
      wrap = rem_sum >= {1'b0, span_ff};
      last_line = (mode_ff == MODE_POINT) || ({1'b0, span_ff} == step_ff);

      start.go = accept && req_chan.func && (mode_ff != MODE_IDLE);
      start.skip_window = sent_ff && ((mode_ff == MODE_VERT) || (mode_ff == MODE_HORIZ));

      mode_in  = mode_ff;
      maj_s_in = maj_s_ff;
      maj_e_in = maj_e_ff;
      min_s_in = min_s_ff;
      span_in  = span_ff;
      absd_in  = absd_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      color_in = color_ff;
      sent_in  = sent_ff;
      win_in   = win_ff;

      if (accept && !req_chan.func) begin
         color_in = req_chan.pixel_color;
         step_in  = '0;
         quot_in  = '0;
         rem_in   = '0;
         sent_in  = 1'b0;
         absd_in  = '0;
         neg_in   = 1'b0;
         if (xs == xe && ys == ye) begin
            mode_in  = MODE_POINT;
            maj_s_in = xs;
            maj_e_in = xs;
            min_s_in = ys;
            span_in  = '0;
         end else if (xs == xe) begin
            mode_in  = MODE_VERT;
            maj_s_in = (ys < ye) ? ys : ye;
            maj_e_in = (ys < ye) ? ye : ys;
            min_s_in = xs;
            span_in  = dy;
         end else if (ys == ye) begin
            mode_in  = MODE_HORIZ;
            maj_s_in = (xs < xe) ? xs : xe;
            maj_e_in = (xs < xe) ? xe : xs;
            min_s_in = ys;
            span_in  = dx;
         end else if (dy > dx) begin
            swap     = ys > ye;
            mode_in  = MODE_STEEP;
            maj_s_in = swap ? ye : ys;
            maj_e_in = swap ? ys : ye;
            min_s_in = swap ? xe : xs;
            span_in  = dy;
            absd_in  = dx;
            neg_in   = swap ? (xs < xe) : (xe < xs);
         end else begin
            swap     = xs > xe;
            mode_in  = MODE_SHALLOW;
            maj_s_in = swap ? xe : xs;
            maj_e_in = swap ? xs : xe;
            min_s_in = swap ? ye : ys;
            span_in  = dx;
            absd_in  = dy;
            neg_in   = swap ? (ys < ye) : (ye < ys);
         end
      end else if (start.go) begin
         unique case (mode_ff)
            MODE_VERT: begin
               win_in.col1 = min_s_ff;
               win_in.col2 = min_s_ff;
               win_in.row1 = maj_s_ff;
               win_in.row2 = maj_e_ff;
            end
            MODE_HORIZ: begin
               win_in.col1 = maj_s_ff;
               win_in.col2 = maj_e_ff;
               win_in.row1 = min_s_ff;
               win_in.row2 = min_s_ff;
            end
            default: begin
               win_in.col1 = px;
               win_in.col2 = px;
               win_in.row1 = py;
               win_in.row2 = py;
            end
         endcase
         win_in.color     = color_ff;
         win_in.last_line = last_line;
         step_in = step_ff + 17'd1;
         sent_in = 1'b1;
         quot_in = quot_ff + 16'(wrap);
         rem_in  = wrap ? 16'(rem_sum - {1'b0, span_ff}) : rem_sum[15:0];
         if (last_line) begin
            mode_in = MODE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
      maj_s_ff <= maj_s_in;
      maj_e_ff <= maj_e_in;
      min_s_ff <= min_s_in;
      span_ff  <= span_in;
      absd_ff  <= absd_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      color_ff <= color_in;
      sent_ff  <= sent_in;
      win_ff   <= win_in;
   end

endmodule

[src/ldbw_sequencer.sv]
// Microcoded beat sequencer: control store, step counter and output register.
module ldbw_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  ldbw_pkg::start_type   start,
   input  ldbw_pkg::win_type     win,
   ldbw_rsp_if.source            rsp_chan,
   output logic                  busy
);
   import ldbw_pkg::*;

   localparam int UCODE_DEPTH = 12;
   localparam int PC_BITS = $clog2(UCODE_DEPTH);
   localparam logic [PC_BITS-1:0] STEP_FIRST = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] STEP_COLOR = PC_BITS'(UCODE_DEPTH - 1);

   localparam logic [3:0] SEL_CMD_COL = 4'd0;
   localparam logic [3:0] SEL_CMD_ROW = 4'd1;
   localparam logic [3:0] SEL_CMD_MEM = 4'd2;
   localparam logic [3:0] SEL_COL1_HI = 4'd3;
   localparam logic [3:0] SEL_COL1_LO = 4'd4;
   localparam logic [3:0] SEL_COL2_HI = 4'd5;
   localparam logic [3:0] SEL_COL2_LO = 4'd6;
   localparam logic [3:0] SEL_ROW1_HI = 4'd7;
   localparam logic [3:0] SEL_ROW1_LO = 4'd8;
   localparam logic [3:0] SEL_ROW2_HI = 4'd9;
   localparam logic [3:0] SEL_ROW2_LO = 4'd10;
   localparam logic [3:0] SEL_COLOR   = 4'd11;

   typedef struct packed {
      logic       is_cmd;
      logic [3:0] sel;
      logic       done;
   } ucode_type;

   function automatic ucode_type ucode_fetch(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      unique case (pc)
         PC_BITS'(0):  w = '{is_cmd: 1'b1, sel: SEL_CMD_COL, done: 1'b0};
         PC_BITS'(1):  w = '{is_cmd: 1'b0, sel: SEL_COL1_HI, done: 1'b0};
         PC_BITS'(2):  w = '{is_cmd: 1'b0, sel: SEL_COL1_LO, done: 1'b0};
         PC_BITS'(3):  w = '{is_cmd: 1'b0, sel: SEL_COL2_HI, done: 1'b0};
         PC_BITS'(4):  w = '{is_cmd: 1'b0, sel: SEL_COL2_LO, done: 1'b0};
         PC_BITS'(5):  w = '{is_cmd: 1'b1, sel: SEL_CMD_ROW, done: 1'b0};
         PC_BITS'(6):  w = '{is_cmd: 1'b0, sel: SEL_ROW1_HI, done: 1'b0};
         PC_BITS'(7):  w = '{is_cmd: 1'b0, sel: SEL_ROW1_LO, done: 1'b0};
         PC_BITS'(8):  w = '{is_cmd: 1'b0, sel: SEL_ROW2_HI, done: 1'b0};
         PC_BITS'(9):  w = '{is_cmd: 1'b0, sel: SEL_ROW2_LO, done: 1'b0};
         PC_BITS'(10): w = '{is_cmd: 1'b1, sel: SEL_CMD_MEM, done: 1'b0};
         PC_BITS'(11): w = '{is_cmd: 1'b0, sel: SEL_COLOR,   done: 1'b1};
         default:      w = '{is_cmd: 1'b0, sel: SEL_COLOR,   done: 1'b1};
      endcase
      return w;
   endfunction

   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               busy_ff, busy_in;
   logic               valid_ff, valid_in;
   logic               cmd_ff, cmd_in;
   logic [15:0]        value_ff, value_in;
   logic               lpix_ff, lpix_in;
   logic               lline_ff, lline_in;

   ucode_type word;
   logic      emit;

   assign busy = busy_ff;
   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.is_command = cmd_ff;
   assign rsp_chan.bus_value = value_ff;
   assign rsp_chan.last_of_pixel = lpix_ff;
   assign rsp_chan.last_of_line = lline_ff;

   always_comb begin
      word = ucode_fetch(pc_ff);
      emit = busy_ff && (!valid_ff || rsp_chan.ready);

      pc_in    = pc_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      value_in = value_ff;
      lpix_in  = lpix_ff;
      lline_in = lline_ff;

      unique case (word.sel)
         SEL_CMD_COL: value_in = CMD_COLWIN;
         SEL_CMD_ROW: value_in = CMD_ROWWIN;
         SEL_CMD_MEM: value_in = CMD_MEMWR;
         SEL_COL1_HI: value_in = (win.col1 >> 8) & BYTE_MASK;
         SEL_COL1_LO: value_in = win.col1 & BYTE_MASK;
         SEL_COL2_HI: value_in = (win.col2 >> 8) & BYTE_MASK;
         SEL_COL2_LO: value_in = win.col2 & BYTE_MASK;
         SEL_ROW1_HI: value_in = (win.row1 >> 8) & BYTE_MASK;
         SEL_ROW1_LO: value_in = win.row1 & BYTE_MASK;
         SEL_ROW2_HI: value_in = (win.row2 >> 8) & BYTE_MASK;
         SEL_ROW2_LO: value_in = win.row2 & BYTE_MASK;
         default:     value_in = win.color;
      endcase

      if (emit) begin
         valid_in = 1'b1;
         cmd_in   = word.is_cmd;
         lpix_in  = word.done;
         lline_in = word.done && win.last_line;
      end else begin
         value_in = value_ff;
         if (rsp_chan.ready) begin
            valid_in = 1'b0;
         end
      end

      if (start.go) begin
         busy_in = 1'b1;
         pc_in   = start.skip_window ? STEP_COLOR : STEP_FIRST;
      end else if (emit) begin
         if (word.done) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + PC_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      pc_ff    <= pc_in;
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      lpix_ff  <= lpix_in;
      lline_ff <= lline_in;
   end

endmodule
